// ===== sv/pictl_pkg.sv =====
// Shared types and constants for the PI controller with thermal plant model.
`default_nettype none

package pictl_pkg;

   // Width of the gain and step registers.
   localparam int GAIN_W = 32;

   // Highest setpoint that is accepted: 120.0 degrees in Q16.16.
   localparam logic signed [31:0] SETPOINT_MAX = 32'sd7864320;

   // Configuration register reset values.
   localparam logic [31:0] PROP_GAIN_RST  = 32'd131072;
   localparam logic [31:0] INT_GAIN_RST   = 32'd21474836;
   localparam logic [31:0] STEP_RST       = 32'd2147484;
   localparam logic [31:0] UPPER_RST      = 32'd7864320;
   localparam logic [31:0] LOWER_RST      = 32'hFF880000;
   localparam logic [31:0] AMBIENT_RST    = 32'd0;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_PROP_GAIN = 3'd0,
      CSR_INT_GAIN  = 3'd1,
      CSR_STEP      = 3'd2,
      CSR_UPPER     = 3'd3,
      CSR_LOWER     = 3'd4,
      CSR_AMBIENT   = 3'd5
   } csr_index_type;

   // Input beat.
   typedef struct packed {
      logic signed [31:0] setpoint;
      logic               restart;
   } req_type;

   // Result beat.
   typedef struct packed {
      logic signed [31:0] plant_temperature;
      logic signed [31:0] applied_drive;
      logic               setpoint_rejected;
   } rsp_type;

   // Control toward the serial multiplier.
   typedef struct packed {
      logic start;
      logic frac16;
   } mul_ctl_type;

endpackage

`default_nettype wire

// ===== sv/pi_controller_rk4_thermal_plant.sv =====
// Top level: velocity-form PI controller driving an RK4 first-order plant model.
// An accepted beat runs the PI update, six serial products and a serial divide by six, then
// its result is registered; a rejected setpoint goes straight to the result state instead.
// Throughput: one item at a time, with requests stalled until the result is loaded, and
// paced by the bit-serial multiplier (six products) and the bit-serial divide by six.
// Reset: synchronous; registers return to their defaults and the state to zero.
`default_nettype none

module pi_controller_rk4_thermal_plant #(
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire pictl_pkg::req_type req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output pictl_pkg::rsp_type      rsp_data,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_wdata
);
   import pictl_pkg::*;

   localparam int W   = VALUE_WIDTH;
   localparam int XW  = ((W > 32) ? W : 32) + 1;
   localparam int DCW = $clog2(W + 2);

   localparam logic signed [XW-1:0] VMAX_X = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [XW-1:0] VMIN_X = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};
   localparam logic signed [XW-1:0] OMAX_X = {{(XW-31){1'b0}}, {31{1'b1}}};
   localparam logic signed [XW-1:0] OMIN_X = {{(XW-31){1'b1}}, {31{1'b0}}};

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_ERR   = 9'b000000010,
      ST_MGO   = 9'b000000100,
      ST_MWAIT = 9'b000001000,
      ST_CLAMP = 9'b000010000,
      ST_E0    = 9'b000100000,
      ST_DIVGO = 9'b001000000,
      ST_DIV   = 9'b010000000,
      ST_FIN   = 9'b100000000
   } state_type;

   typedef enum logic [2:0] {
      PH_KP = 3'd0,
      PH_KI = 3'd1,
      PH_D1 = 3'd2,
      PH_D2 = 3'd3,
      PH_D3 = 3'd4,
      PH_D4 = 3'd5
   } phase_type;

   // Saturating add and subtract on the value range.
   function automatic logic signed [W-1:0] add_s(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
      logic [W:0] s;
      s = {a[W-1], a} + {b[W-1], b};
      if (s[W] != s[W-1]) begin
         return s[W] ? VMIN_X[W-1:0] : VMAX_X[W-1:0];
      end
      return s[W-1:0];
   endfunction

   function automatic logic signed [W-1:0] sub_s(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
      logic [W:0] s;
      s = {a[W-1], a} - {b[W-1], b};
      if (s[W] != s[W-1]) begin
         return s[W] ? VMIN_X[W-1:0] : VMAX_X[W-1:0];
      end
      return s[W-1:0];
   endfunction

   // A 32-bit signed field brought into the value range.
   function automatic logic signed [W-1:0] from32(input logic signed [31:0] v);
      logic signed [XW-1:0] x;
      x = XW'(v);
      if (x > VMAX_X) return VMAX_X[W-1:0];
      if (x < VMIN_X) return VMIN_X[W-1:0];
      return x[W-1:0];
   endfunction

   // A value saturated to a 32-bit output field.
   function automatic logic [31:0] to32(input logic signed [W-1:0] v);
      logic signed [XW-1:0] x;
      x = XW'(v);
      if (x > OMAX_X) return OMAX_X[31:0];
      if (x < OMIN_X) return OMIN_X[31:0];
      return x[31:0];
   endfunction

   state_type           state_ff;
   phase_type           phase_ff;
   logic [31:0]         prop_gain_ff, int_gain_ff, step_ff, upper_ff, lower_ff, ambient_ff;
   logic signed [W-1:0] sp_ff, temp_ff, last_ff, drive_ff, err_ff, cand_ff, e0_ff;
   logic signed [W-1:0] dprev_ff, sum_ff;
   logic                reject_ff;
   logic [W:0]          dm_ff;
   logic [2:0]          drem_ff;
   logic                dneg_ff;
   logic [DCW-1:0]      dcnt_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;

   logic                accept;
   logic                reject_in;
   logic signed [W-1:0] sp_in, amb_w, upper_w, lower_w;
   mul_ctl_type         mul_ctl;
   logic signed [W-1:0] mul_a;
   logic [GAIN_W-1:0]   mul_b;
   logic                mul_done;
   logic signed [W-1:0] mul_result;
   logic [3:0]          div_t;
   logic                div_ge;
   logic [W:0]          sum_ext;
   logic signed [W-1:0] quot_s, temp_in;
   logic                out_free;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Register and setpoint values in the working range.
   always_comb begin
      sp_in     = from32(req_data.setpoint);
      reject_in = req_data.setpoint[31] || (req_data.setpoint > SETPOINT_MAX);
      amb_w     = from32(ambient_ff);
      upper_w   = from32(upper_ff);
      lower_w   = from32(lower_ff);
   end

   // Multiplier operands for each product of the tick.
   always_comb begin
      mul_ctl.start  = (state_ff == ST_MGO);
      mul_ctl.frac16 = (phase_ff == PH_KP);
      case (phase_ff)
         PH_KP: begin
            mul_a = sub_s(err_ff, last_ff);
            mul_b = prop_gain_ff;
         end
         PH_KI: begin
            mul_a = err_ff;
            mul_b = int_gain_ff;
         end
         PH_D1: begin
            mul_a = e0_ff;
            mul_b = step_ff;
         end
         PH_D2, PH_D3: begin
            mul_a = sub_s(e0_ff, dprev_ff >>> 1);
            mul_b = step_ff;
         end
         PH_D4: begin
            mul_a = sub_s(e0_ff, dprev_ff);
            mul_b = step_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   pictl_mul #(
      .W(W)
   ) u_mul (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mul_ctl),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .done   (mul_done),
      .result (mul_result)
   );

   // Restoring divide by six, one quotient bit per cycle.
   always_comb begin
      div_t   = {drem_ff, dm_ff[W]};
      div_ge  = (div_t >= 4'd6);
      sum_ext = {sum_ff[W-1], sum_ff};
      quot_s  = dneg_ff ? -dm_ff[W-1:0] : dm_ff[W-1:0];
      temp_in = add_s(temp_ff, quot_s);
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff <= PROP_GAIN_RST;
         int_gain_ff  <= INT_GAIN_RST;
         step_ff      <= STEP_RST;
         upper_ff     <= UPPER_RST;
         lower_ff     <= LOWER_RST;
         ambient_ff   <= AMBIENT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PROP_GAIN: prop_gain_ff <= csr_wdata;
            CSR_INT_GAIN:  int_gain_ff  <= csr_wdata;
            CSR_STEP:      step_ff      <= csr_wdata;
            CSR_UPPER:     upper_ff     <= csr_wdata;
            CSR_LOWER:     lower_ff     <= csr_wdata;
            CSR_AMBIENT:   ambient_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Tick sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_KP;
         temp_ff      <= '0;
         last_ff      <= '0;
         drive_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         dcnt_ff      <= '0;
      end else begin
         // A result beat taken here is cleared unless a new one is loaded below.
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_FIN)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  sp_ff     <= sp_in;
                  reject_ff <= reject_in;
                  if (!reject_in && req_data.restart) begin
                     temp_ff  <= amb_w;
                     drive_ff <= '0;
                     last_ff  <= sub_s(sp_in, amb_w);
                  end
                  state_ff <= reject_in ? ST_FIN : ST_ERR;
               end
            end
            ST_ERR: begin
               err_ff   <= sub_s(sp_ff, temp_ff);
               phase_ff <= PH_KP;
               state_ff <= ST_MGO;
            end
            ST_MGO: begin
               state_ff <= ST_MWAIT;
            end
            ST_MWAIT: begin
               if (mul_done) begin
                  state_ff <= ST_MGO;
                  case (phase_ff)
                     PH_KP: begin
                        cand_ff  <= add_s(drive_ff, mul_result);
                        phase_ff <= PH_KI;
                     end
                     PH_KI: begin
                        cand_ff  <= add_s(cand_ff, mul_result);
                        state_ff <= ST_CLAMP;
                     end
                     PH_D1: begin
                        dprev_ff <= mul_result;
                        sum_ff   <= mul_result;
                        phase_ff <= PH_D2;
                     end
                     PH_D2: begin
                        dprev_ff <= mul_result;
                        sum_ff   <= add_s(sum_ff, add_s(mul_result, mul_result));
                        phase_ff <= PH_D3;
                     end
                     PH_D3: begin
                        dprev_ff <= mul_result;
                        sum_ff   <= add_s(sum_ff, add_s(mul_result, mul_result));
                        phase_ff <= PH_D4;
                     end
                     PH_D4: begin
                        sum_ff   <= add_s(sum_ff, mul_result);
                        state_ff <= ST_DIVGO;
                     end
                     default: begin
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end
            end
            ST_CLAMP: begin
               // The upper limit is tested first; the upper one wins when both apply.
               if (cand_ff > upper_w) begin
                  cand_ff <= upper_w;
               end else if (cand_ff < lower_w) begin
                  cand_ff <= lower_w;
               end
               state_ff <= ST_E0;
            end
            ST_E0: begin
               e0_ff    <= sub_s(add_s(amb_w, cand_ff), temp_ff);
               phase_ff <= PH_D1;
               state_ff <= ST_MGO;
            end
            ST_DIVGO: begin
               // Negative sums divide the magnitude plus five, giving a floor.
               dneg_ff  <= sum_ff[W-1];
               dm_ff    <= sum_ff[W-1] ? (~sum_ext + (W+1)'(6)) : sum_ext;
               drem_ff  <= '0;
               dcnt_ff  <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               drem_ff <= div_ge ? 3'(div_t - 4'd6) : div_t[2:0];
               dm_ff   <= {dm_ff[W-1:0], div_ge};
               dcnt_ff <= dcnt_ff + 1'b1;
               if (dcnt_ff == DCW'(W)) begin
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff.setpoint_rejected <= reject_ff;
                  if (reject_ff) begin
                     rsp_data_ff.plant_temperature <= to32(temp_ff);
                     rsp_data_ff.applied_drive     <= to32(drive_ff);
                  end else begin
                     temp_ff  <= temp_in;
                     drive_ff <= cand_ff;
                     last_ff  <= err_ff;
                     rsp_data_ff.plant_temperature <= to32(temp_in);
                     rsp_data_ff.applied_drive     <= to32(cand_ff);
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== sv/pictl_mul.sv =====
// Bit-serial signed by unsigned multiplier with floor shift and saturation.
`default_nettype none

module pictl_mul #(
   parameter int W = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire pictl_pkg::mul_ctl_type       ctl,
   input  wire logic signed [W-1:0]          op_a,
   input  wire logic [pictl_pkg::GAIN_W-1:0] op_b,
   output logic                              done,
   output logic signed [W-1:0]               result
);
   import pictl_pkg::*;

   localparam int CW = $clog2(GAIN_W);
   localparam int RW = W + 17;

   logic signed [W-1:0]  a_ff;
   logic [GAIN_W-1:0]    b_ff;
   logic [W:0]           hi_ff;
   logic [GAIN_W-1:0]    lo_ff;
   logic [CW-1:0]        cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic                 frac16_ff;

   logic [W:0]           sum_in;
   logic [W+GAIN_W:0]    full;
   logic [RW-1:0]        shifted;

   // One multiplier bit per cycle: add the operand, then shift right.
   always_comb begin
      sum_in = hi_ff + (b_ff[0] ? {a_ff[W-1], a_ff} : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            a_ff      <= op_a;
            b_ff      <= op_b;
            hi_ff     <= '0;
            lo_ff     <= '0;
            cnt_ff    <= '0;
            frac16_ff <= ctl.frac16;
            busy_ff   <= 1'b1;
         end else if (busy_ff) begin
            hi_ff  <= {sum_in[W], sum_in[W:1]};
            lo_ff  <= {sum_in[0], lo_ff[GAIN_W-1:1]};
            b_ff   <= {1'b0, b_ff[GAIN_W-1:1]};
            cnt_ff <= cnt_ff + 1'b1;
            if (&cnt_ff) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Floor shift by 16 or 32, then saturate to the value range.
   always_comb begin
      full = {hi_ff, lo_ff};
      if (frac16_ff) begin
         shifted = full[W+GAIN_W:16];
      end else begin
         shifted = {{16{full[W+GAIN_W]}}, full[W+GAIN_W:GAIN_W]};
      end
      if ((&shifted[RW-1:W-1]) || !(|shifted[RW-1:W-1])) begin
         result = shifted[W-1:0];
      end else if (shifted[RW-1]) begin
         result = {1'b1, {(W-1){1'b0}}};
      end else begin
         result = {1'b0, {(W-1){1'b1}}};
      end
   end

   assign done = done_ff;

endmodule

`default_nettype wire

// ===== sim/tb_pi_controller_rk4_thermal_plant.sv =====
// Testbench for the PI controller with RK4 thermal plant: directed table, extreme settings, then random ticks.
`timescale 1ns / 1ps

module tb_pi_controller_rk4_thermal_plant;
   import pictl_pkg::*;

   localparam longint VMAX = 64'sd2147483647;
   localparam longint VMIN = -64'sd2147483648;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   // Controller settings and plant state as the checker sees them.
   logic [31:0] kp, ki_dt, step_h, lim_hi, lim_lo, amb_reg;
   longint plant_temp, prev_error, drive_level;

   rsp_type expected_beats[$];
   int failures = 0;
   int idle_cycles = 0;
   bit hold_off = 1'b0;
   bit drain_done = 1'b0;

   pi_controller_rk4_thermal_plant uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic longint clip(longint v);
      if (v > VMAX) return VMAX;
      if (v < VMIN) return VMIN;
      return v;
   endfunction

   function automatic longint sx(logic [31:0] x);
      return longint'(signed'(x));
   endfunction

   // Product floored toward minus infinity, then saturated.
   function automatic longint scaled_mul(longint a, logic [31:0] b, int shift);
      logic signed [127:0] p;
      p = 128'(signed'(a)) * $signed({96'd0, b});
      p = p >>> shift;
      if (p > VMAX) return VMAX;
      if (p < VMIN) return VMIN;
      return longint'(p);
   endfunction

   function automatic longint floor_div6(longint x);
      if (x >= 0) return x / 6;
      return -((-x + 5) / 6);
   endfunction

   function automatic rsp_type control_tick(req_type r);
      rsp_type o;
      longint sp, amb, hi, lo, err, cand, e0, d1, d2, d3, d4, sum;
      sp = sx(r.setpoint);
      amb = sx(amb_reg);
      hi = sx(lim_hi);
      lo = sx(lim_lo);
      o.setpoint_rejected = 1'b0;
      if (sp < 0 || sp > sx(SETPOINT_MAX)) begin
         o.plant_temperature = plant_temp[31:0];
         o.applied_drive = drive_level[31:0];
         o.setpoint_rejected = 1'b1;
         return o;
      end
      if (r.restart) begin
         plant_temp = amb;
         drive_level = 0;
         prev_error = clip(sp - amb);
      end
      err = clip(sp - plant_temp);
      cand = clip(drive_level + scaled_mul(clip(err - prev_error), kp, 16));
      cand = clip(cand + scaled_mul(err, ki_dt, 32));
      if (cand > hi) cand = hi;
      else if (cand < lo) cand = lo;
      e0 = clip(clip(amb + cand) - plant_temp);
      d1 = scaled_mul(e0, step_h, 32);
      d2 = scaled_mul(clip(e0 - scaled_mul(d1, 32'h8000_0000, 32)), step_h, 32);
      d3 = scaled_mul(clip(e0 - scaled_mul(d2, 32'h8000_0000, 32)), step_h, 32);
      d4 = scaled_mul(clip(e0 - d3), step_h, 32);
      sum = clip(d1 + clip(d2 + d2));
      sum = clip(sum + clip(d3 + d3));
      sum = clip(sum + d4);
      plant_temp = clip(plant_temp + floor_div6(sum));
      drive_level = cand;
      prev_error = err;
      o.plant_temperature = plant_temp[31:0];
      o.applied_drive = drive_level[31:0];
      return o;
   endfunction

   // Compare each result beat with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_beats.size() == 0) begin
            $display("%0t: unexpected result beat %h", $time, rsp_data);
            failures++;
         end else begin
            rsp_type e;
            e = expected_beats.pop_front();
            if (rsp_data.plant_temperature !== e.plant_temperature) begin
               $display("%0t: temperature expected %h actual %h", $time,
                        e.plant_temperature, rsp_data.plant_temperature);
               failures++;
            end
            if (rsp_data.applied_drive !== e.applied_drive) begin
               $display("%0t: drive expected %h actual %h", $time,
                        e.applied_drive, rsp_data.applied_drive);
               failures++;
            end
            if (rsp_data.setpoint_rejected !== e.setpoint_rejected) begin
               $display("%0t: reject expected %b actual %b", $time,
                        e.setpoint_rejected, rsp_data.setpoint_rejected);
               failures++;
            end
         end
      end
   end

   // Receiver stall pattern, with stall-free stretches and a long hold-off on request.
   always @(posedge clock) begin
      int phase;
      phase = ($time / 10) % 600;
      if (hold_off) rsp_stall <= 1'b1;
      else if (phase < 150) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 3) == 0);
   end

   // Watchdog on cycles without any accepted beat.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)
          || hold_off || reset || drain_done)
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   task automatic write_csr(csr_index_type idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_PROP_GAIN: kp = value;
         CSR_INT_GAIN:  ki_dt = value;
         CSR_STEP:      step_h = value;
         CSR_UPPER:     lim_hi = value;
         CSR_LOWER:     lim_lo = value;
         default:       amb_reg = value;
      endcase
      @(posedge clock);
   endtask

   // Offer one beat, predict it on acceptance; an optional random gap first.
   task automatic send_tick(req_type r, bit allow_gap);
      if (allow_gap && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_beats.push_back(control_tick(r));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] random_setpoint();
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return 32'h8000_0000 | $urandom();
         2: return SETPOINT_MAX + $urandom_range(1, 1000);
         default: return $urandom_range(0, SETPOINT_MAX);
      endcase
   endfunction

   typedef struct {
      logic [31:0] setpoint;
      bit          restart;
      bit          known;
      rsp_type     result;
   } stim_row_type;

   stim_row_type directed[] = '{
      '{32'sd0,         1'b0, 1'b1, '{32'd0, 32'd0, 1'b0}},
      '{32'hFFFF_FFFF,  1'b0, 1'b1, '{32'd0, 32'd0, 1'b1}},
      '{32'h8000_0000,  1'b1, 1'b1, '{32'd0, 32'd0, 1'b1}},
      '{32'h7FFF_FFFF,  1'b0, 1'b1, '{32'd0, 32'd0, 1'b1}},
      '{32'sd7864321,   1'b1, 1'b1, '{32'd0, 32'd0, 1'b1}},
      '{32'sd7864320,   1'b1, 1'b0, '{32'd0, 32'd0, 1'b0}},
      '{32'sd7864320,   1'b0, 1'b0, '{32'd0, 32'd0, 1'b0}},
      '{32'sd1310720,   1'b0, 1'b0, '{32'd0, 32'd0, 1'b0}},
      '{32'sd0,         1'b0, 1'b0, '{32'd0, 32'd0, 1'b0}},
      '{32'h8000_0000,  1'b0, 1'b0, '{32'd0, 32'd0, 1'b0}},
      '{32'sd3276800,   1'b1, 1'b0, '{32'd0, 32'd0, 1'b0}},
      '{32'sd3276800,   1'b0, 1'b0, '{32'd0, 32'd0, 1'b0}}
   };

   initial begin
      kp = PROP_GAIN_RST; ki_dt = INT_GAIN_RST; step_h = STEP_RST;
      lim_hi = UPPER_RST; lim_lo = LOWER_RST; amb_reg = AMBIENT_RST;
      plant_temp = 0; prev_error = 0; drive_level = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table; rows with a typed result override the prediction.
      foreach (directed[i]) begin
         req_type r;
         r.setpoint = directed[i].setpoint;
         r.restart = directed[i].restart;
         send_tick(r, 1'b0);
         if (directed[i].known) expected_beats[$] = directed[i].result;
      end
      wait_idle();

      // Extreme gains and step, then zero gains and step with crossed limits.
      write_csr(CSR_PROP_GAIN, 32'hFFFF_FFFF);
      write_csr(CSR_INT_GAIN, 32'hFFFF_FFFF);
      write_csr(CSR_STEP, 32'hFFFF_FFFF);
      write_csr(CSR_UPPER, 32'h7FFF_FFFF);
      write_csr(CSR_LOWER, 32'h8000_0000);
      write_csr(CSR_AMBIENT, 32'h8000_0000);
      for (int i = 0; i < 8; i++) send_tick('{random_setpoint(), i == 0}, 1'b0);
      wait_idle();
      write_csr(CSR_PROP_GAIN, 32'd0);
      write_csr(CSR_INT_GAIN, 32'd0);
      write_csr(CSR_STEP, 32'd0);
      write_csr(CSR_UPPER, 32'h8000_0000);
      write_csr(CSR_LOWER, 32'h7FFF_FFFF);
      write_csr(CSR_AMBIENT, 32'h7FFF_FFFF);
      for (int i = 0; i < 6; i++) send_tick('{random_setpoint(), i == 0}, 1'b0);
      wait_idle();

      // Random phases with random settings; one phase holds the receiver off.
      for (int ph = 0; ph < 6; ph++) begin
         write_csr(CSR_PROP_GAIN, $urandom_range(0, 32'h0004_0000));
         write_csr(CSR_INT_GAIN, $urandom());
         write_csr(CSR_STEP, $urandom());
         write_csr(CSR_UPPER, $urandom_range(0, 32'h0100_0000));
         write_csr(CSR_LOWER, (ph == 3) ? $urandom() : -$urandom_range(0, 32'h0100_0000));
         write_csr(CSR_AMBIENT, (ph == 4) ? $urandom() : $urandom_range(0, 32'h0028_0000));
         if (ph == 2) begin
            fork
               begin
                  hold_off = 1'b1;
                  repeat (3000) @(posedge clock);
                  hold_off = 1'b0;
               end
            join_none
         end
         for (int i = 0; i < 90; i++)
            send_tick('{random_setpoint(), $urandom_range(0, 30) == 0}, 1'b1);
         wait_idle();
      end

      drain_done = 1'b1;
      if (failures == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule
